// ===== design/gnwl_pkg.sv =====
// ----------------------------------------------------------------------------
// gnwl_pkg
// Shared types and constants of the grid neighbour weight locator.
// ----------------------------------------------------------------------------
package gnwl_pkg;

    localparam int NUM_AXES  = 3;
    localparam int POS_W     = 12;
    localparam int IDX_W     = 12;
    localparam int SPACING_W = 12;
    localparam int VOLUME_W  = 13;
    localparam int FIX_W     = 16;
    localparam int FRAC_BITS = 16;
    localparam int WEIGHT_W  = FRAC_BITS + 1;
    localparam int DIST_W    = 17;
    localparam int ORIGIN_W  = 48;
    localparam int CFG_IDX_W = 3;

    // pipeline of one axis lane: entry, index divider, prep, weight divider, output
    localparam int DIV1_STEPS = IDX_W;
    localparam int DIV2_STEPS = WEIGHT_W;
    localparam int LANE_DEPTH = DIV1_STEPS + DIV2_STEPS + 3;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 3'd6;

    localparam logic [SPACING_W-1:0] SPACING_RST  = 12'd64;
    localparam logic [VOLUME_W-1:0]  VOLUME_RST   = 13'd256;
    localparam logic [VOLUME_W-1:0]  VOLUME_MIN   = 13'd2;
    localparam logic [VOLUME_W-1:0]  VOLUME_MAX   = 13'd4096;
    localparam logic [IDX_W-1:0]     LAST_IDX_RST = 12'd3;
    localparam logic [DIST_W-1:0]    LAST_LEN_RST = 17'd1008;
    localparam logic [DIST_W-1:0]    END_PT_RST   = 17'd3576;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE   = 17'h10000;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]    lower_x;
        logic [IDX_W-1:0]    upper_x;
        logic [WEIGHT_W-1:0] weight_x;
        logic [IDX_W-1:0]    lower_y;
        logic [IDX_W-1:0]    upper_y;
        logic [WEIGHT_W-1:0] weight_y;
        logic [IDX_W-1:0]    lower_z;
        logic [IDX_W-1:0]    upper_z;
        logic [WEIGHT_W-1:0] weight_z;
    } out_t;

    typedef struct packed {
        logic [SPACING_W-1:0] spacing;
        logic [FIX_W-1:0]     origin;
        logic [DIST_W-1:0]    end_point;
        logic [IDX_W-1:0]     last_idx;
        logic [DIST_W-1:0]    last_len;
    } axis_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]    lower;
        logic [IDX_W-1:0]    upper;
        logic [WEIGHT_W-1:0] weight;
    } axis_res_t;

    typedef struct packed {
        logic             low;
        logic             high;
        logic [3:0]       frac;
        logic [IDX_W-1:0] num;
        logic [IDX_W-1:0] rem;
        logic [IDX_W-1:0] quo;
    } div1_t;

    typedef struct packed {
        logic                low;
        logic                high;
        logic [IDX_W-1:0]    lo;
        logic [IDX_W-1:0]    up;
        logic [DIST_W-1:0]   cell_len;
        logic [WEIGHT_W-1:0] num;
        logic [DIST_W-1:0]   rem;
        logic [WEIGHT_W-1:0] quo;
    } div2_t;

endpackage

// ===== design/gnwl_cfg.sv =====
// ----------------------------------------------------------------------------
// gnwl_cfg
// Configuration registers and the sequential divider that derives the
// per-axis cell count, last cell length and grid end point.
// ----------------------------------------------------------------------------
module gnwl_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [gnwl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gnwl_pkg::ORIGIN_W-1:0]       cfg_data,
    output logic                                busy,
    output gnwl_pkg::axis_cfg_t [2:0]           axis_cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [3:0] STEP_LAST = 4'(gnwl_pkg::IDX_W - 1);

    logic [gnwl_pkg::SPACING_W-1:0] sp_reg [0:2];
    logic [gnwl_pkg::VOLUME_W-1:0]  vol_reg [0:2];
    logic [gnwl_pkg::ORIGIN_W-1:0]  org_reg;
    logic [gnwl_pkg::IDX_W-1:0]     last_reg [0:2];
    logic [gnwl_pkg::DIST_W-1:0]    lcl_reg [0:2];
    logic [gnwl_pkg::DIST_W-1:0]    gep_reg [0:2];

    logic [1:0]                     state_reg;
    logic [1:0]                     axis_reg;
    logic [3:0]                     step_reg;
    logic [gnwl_pkg::IDX_W-1:0]     num_reg;
    logic [gnwl_pkg::IDX_W-1:0]     rem_reg;
    logic [gnwl_pkg::IDX_W-1:0]     quo_reg;

    logic                           write_hit;
    logic [gnwl_pkg::SPACING_W-1:0] sp_wr;
    logic [gnwl_pkg::VOLUME_W-1:0]  vol_wr;
    logic [1:0]                     vol_idx;
    logic [gnwl_pkg::SPACING_W-1:0] sp_cur;
    logic [gnwl_pkg::VOLUME_W-1:0]  vol_cur;
    logic [gnwl_pkg::IDX_W:0]       trial;
    logic                           ge;
    logic [gnwl_pkg::IDX_W-1:0]     rem_next;
    logic [gnwl_pkg::IDX_W-1:0]     quo_next;
    logic [gnwl_pkg::IDX_W-1:0]     rem_one;
    logic [gnwl_pkg::IDX_W-1:0]     len_m;
    logic [gnwl_pkg::DIST_W-1:0]    gep_next;
    logic [gnwl_pkg::DIST_W-1:0]    lcl_next;

    assign write_hit = cfg_valid && (cfg_index <= gnwl_pkg::REG_ORIGIN);
    assign sp_wr     = (cfg_data[gnwl_pkg::SPACING_W-1:0] == '0) ? 12'd1
                                                         : cfg_data[gnwl_pkg::SPACING_W-1:0];
    assign vol_wr    = (cfg_data[gnwl_pkg::VOLUME_W-1:0] < gnwl_pkg::VOLUME_MIN)
                       ? gnwl_pkg::VOLUME_MIN
                       : ((cfg_data[gnwl_pkg::VOLUME_W-1:0] > gnwl_pkg::VOLUME_MAX)
                          ? gnwl_pkg::VOLUME_MAX : cfg_data[gnwl_pkg::VOLUME_W-1:0]);
    assign vol_idx   = 2'(cfg_index - gnwl_pkg::REG_VOLUME_X);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sp_reg[a]  <= gnwl_pkg::SPACING_RST;
                vol_reg[a] <= gnwl_pkg::VOLUME_RST;
            end
            org_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                gnwl_pkg::REG_SPACING_X, gnwl_pkg::REG_SPACING_Y, gnwl_pkg::REG_SPACING_Z:
                    sp_reg[cfg_index[1:0]] <= sp_wr;
                gnwl_pkg::REG_VOLUME_X, gnwl_pkg::REG_VOLUME_Y, gnwl_pkg::REG_VOLUME_Z:
                    vol_reg[vol_idx] <= vol_wr;
                gnwl_pkg::REG_ORIGIN:
                    org_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // one quotient bit per cycle of (volume - 2) / spacing
    assign sp_cur   = sp_reg[axis_reg];
    assign vol_cur  = vol_reg[axis_reg];
    assign trial    = {rem_reg, num_reg[gnwl_pkg::IDX_W-1]};
    assign ge       = trial >= {1'b0, sp_cur};
    assign rem_next = ge ? 12'(trial - {1'b0, sp_cur}) : trial[gnwl_pkg::IDX_W-1:0];
    assign quo_next = {quo_reg[gnwl_pkg::IDX_W-2:0], ge};

    // remainder of the grid is r + 1; end point is q*spacing + remainder/2
    assign rem_one  = rem_next + 12'd1;
    assign len_m    = 12'(vol_cur - 13'd1) - rem_one;
    assign gep_next = {1'b0, len_m, 4'b0} + {2'b0, rem_one, 3'b0};
    assign lcl_next = {1'b0, rem_one, 4'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
            for (int a = 0; a < 3; a++)
            begin
                last_reg[a] <= gnwl_pkg::LAST_IDX_RST;
                lcl_reg[a]  <= gnwl_pkg::LAST_LEN_RST;
                gep_reg[a]  <= gnwl_pkg::END_PT_RST;
            end
        end
        else if (write_hit)
        begin
            state_reg <= ST_LOAD;
            axis_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    ;
                ST_LOAD:
                begin
                    state_reg <= ST_RUN;
                    step_reg  <= '0;
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        last_reg[axis_reg] <= quo_next;
                        lcl_reg[axis_reg]  <= lcl_next;
                        gep_reg[axis_reg]  <= gep_next;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            num_reg <= 12'(vol_cur - 13'd2);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else
        begin
            num_reg <= {num_reg[gnwl_pkg::IDX_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    for (genvar a = 0; a < 3; a++)
    begin : g_out
        assign axis_cfg[a].spacing   = sp_reg[a];
        assign axis_cfg[a].origin    = org_reg[16*a +: 16];
        assign axis_cfg[a].end_point = gep_reg[a];
        assign axis_cfg[a].last_idx  = last_reg[a];
        assign axis_cfg[a].last_len  = lcl_reg[a];
    end

endmodule

// ===== design/gnwl_axis_lane.sv =====
// ----------------------------------------------------------------------------
// gnwl_axis_lane
// Pipelined neighbour search of one axis: origin and end checks, a
// restoring divider for the lower index and one for the ratio.
// ----------------------------------------------------------------------------
module gnwl_axis_lane (
    input  logic                           clk,
    input  logic                           en,
    input  logic [gnwl_pkg::POS_W-1:0]     pos,
    input  gnwl_pkg::axis_cfg_t            cfg,
    output gnwl_pkg::axis_res_t            res
);

    localparam int D1 = gnwl_pkg::DIV1_STEPS;
    localparam int D2 = gnwl_pkg::DIV2_STEPS;

    gnwl_pkg::div1_t     d1_reg [0:D1];
    gnwl_pkg::div2_t     d2_reg [0:D2];
    gnwl_pkg::axis_res_t res_reg;

    gnwl_pkg::div1_t     entry_next;
    gnwl_pkg::div2_t     prep_next;
    gnwl_pkg::axis_res_t res_next;

    logic [gnwl_pkg::FIX_W-1:0]    p;
    logic [gnwl_pkg::FIX_W-1:0]    off;
    logic [gnwl_pkg::FIX_W-1:0]    left;
    logic [gnwl_pkg::IDX_W:0]      up_wide;
    logic [gnwl_pkg::DIST_W-1:0]   cell_len;
    logic [gnwl_pkg::WEIGHT_W-1:0] w_sat;

    // entry: compare against origin and grid end, take the offset
    always_comb
    begin
        p                = {pos, 4'b0};
        off              = p - cfg.origin;
        entry_next.low   = (p <= cfg.origin);
        entry_next.high  = ({1'b0, p} >= cfg.end_point);
        entry_next.frac  = off[3:0];
        entry_next.num   = off[gnwl_pkg::FIX_W-1:4];
        entry_next.rem   = '0;
        entry_next.quo   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= entry_next;
        end
    end

    for (genvar k = 1; k <= D1; k++)
    begin : g_div1
        gnwl_pkg::div1_t          nxt;
        logic [gnwl_pkg::IDX_W:0] trial;
        logic                     ge;

        always_comb
        begin
            trial   = {d1_reg[k-1].rem, d1_reg[k-1].num[gnwl_pkg::IDX_W-1]};
            ge      = trial >= {1'b0, cfg.spacing};
            nxt     = d1_reg[k-1];
            nxt.num = {d1_reg[k-1].num[gnwl_pkg::IDX_W-2:0], 1'b0};
            nxt.rem = ge ? 12'(trial - {1'b0, cfg.spacing}) : trial[gnwl_pkg::IDX_W-1:0];
            nxt.quo = {d1_reg[k-1].quo[gnwl_pkg::IDX_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_reg[k] <= nxt;
            end
        end
    end

    // cell length: the cell ending at the last node is (spacing + remainder) / 2
    always_comb
    begin
        left    = {d1_reg[D1].rem, d1_reg[D1].frac};
        up_wide = {1'b0, d1_reg[D1].quo} + 13'd1;
        if (up_wide == {1'b0, cfg.last_idx})
        begin
            cell_len = {2'b0, cfg.spacing, 3'b0} + {1'b0, cfg.last_len[gnwl_pkg::DIST_W-1:1]};
        end
        else
        begin
            cell_len = {1'b0, cfg.spacing, 4'b0};
        end
        if (cell_len == '0)
        begin
            cell_len = 17'd1;
        end
        prep_next.low      = d1_reg[D1].low;
        prep_next.high     = d1_reg[D1].high;
        prep_next.lo       = d1_reg[D1].quo;
        prep_next.up       = (up_wide > {1'b0, cfg.last_idx}) ? cfg.last_idx
                                                              : up_wide[gnwl_pkg::IDX_W-1:0];
        prep_next.cell_len = cell_len;
        prep_next.num      = {left[0], 16'b0};
        prep_next.rem      = {2'b0, left[gnwl_pkg::FIX_W-1:1]};
        prep_next.quo      = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg[0] <= prep_next;
        end
    end

    for (genvar k = 1; k <= D2; k++)
    begin : g_div2
        gnwl_pkg::div2_t           nxt;
        logic [gnwl_pkg::DIST_W:0] trial;
        logic                      ge;

        always_comb
        begin
            trial   = {d2_reg[k-1].rem, d2_reg[k-1].num[gnwl_pkg::WEIGHT_W-1]};
            ge      = trial >= {1'b0, d2_reg[k-1].cell_len};
            nxt     = d2_reg[k-1];
            nxt.num = {d2_reg[k-1].num[gnwl_pkg::WEIGHT_W-2:0], 1'b0};
            nxt.rem = ge ? 17'(trial - {1'b0, d2_reg[k-1].cell_len})
                         : trial[gnwl_pkg::DIST_W-1:0];
            nxt.quo = {d2_reg[k-1].quo[gnwl_pkg::WEIGHT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d2_reg[k] <= nxt;
            end
        end
    end

    always_comb
    begin
        w_sat = (d2_reg[D2].quo > gnwl_pkg::WEIGHT_ONE) ? gnwl_pkg::WEIGHT_ONE
                                                         : d2_reg[D2].quo;
        if (d2_reg[D2].low)
        begin
            res_next = '0;
        end
        else if (d2_reg[D2].high)
        begin
            res_next.lower  = cfg.last_idx;
            res_next.upper  = cfg.last_idx;
            res_next.weight = '0;
        end
        else
        begin
            res_next.lower  = d2_reg[D2].lo;
            res_next.upper  = d2_reg[D2].up;
            res_next.weight = w_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/grid_neighbour_weight_locator.sv =====
// ----------------------------------------------------------------------------
// grid_neighbour_weight_locator
// Lower and upper grid node and interpolation ratio per axis of a 3D voxel.
// ----------------------------------------------------------------------------
// One position word is taken per cycle unless the lanes stall or the grid is
// being recomputed. Each axis lane holds an entry stage, a 12-step index
// divider, a prep stage, a 17-step ratio divider and the output register. The
// three axes run in parallel lanes. A one-word skid register behind the lanes
// holds a result the consumer has not taken; the lanes stall while it is full.
// After each configuration write a serial divider recomputes the grid of all
// three axes, one axis after the other, and no position word is taken during
// that time.
module grid_neighbour_weight_locator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pos_valid,
    output logic                              pos_ready,
    input  gnwl_pkg::in_t                     pos_word,
    output logic                              res_valid,
    input  logic                              res_ready,
    output gnwl_pkg::out_t                    res_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gnwl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gnwl_pkg::ORIGIN_W-1:0]     cfg_data
);

    localparam int DEPTH = gnwl_pkg::LANE_DEPTH;

    gnwl_pkg::axis_cfg_t [2:0]     axis_cfg;
    gnwl_pkg::axis_res_t           lane_res [0:2];
    logic [gnwl_pkg::POS_W-1:0]    lane_pos [0:2];
    gnwl_pkg::out_t                lane_word;

    logic                          busy;
    logic                          en;
    logic                          accept;
    logic [DEPTH-1:0]              vld_reg;
    logic [DEPTH-1:0]              vld_next;
    logic                          skid_full_reg;
    logic                          skid_full_next;
    gnwl_pkg::out_t                skid_reg;

    gnwl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .axis_cfg  (axis_cfg)
    );

    assign lane_pos[0] = pos_word.pos_x;
    assign lane_pos[1] = pos_word.pos_y;
    assign lane_pos[2] = pos_word.pos_z;

    for (genvar a = 0; a < gnwl_pkg::NUM_AXES; a++)
    begin : g_lane
        gnwl_axis_lane u_lane (
            .clk (clk),
            .en  (en),
            .pos (lane_pos[a]),
            .cfg (axis_cfg[a]),
            .res (lane_res[a])
        );
    end

    assign lane_word.lower_x  = lane_res[0].lower;
    assign lane_word.upper_x  = lane_res[0].upper;
    assign lane_word.weight_x = lane_res[0].weight;
    assign lane_word.lower_y  = lane_res[1].lower;
    assign lane_word.upper_y  = lane_res[1].upper;
    assign lane_word.weight_y = lane_res[1].weight;
    assign lane_word.lower_z  = lane_res[2].lower;
    assign lane_word.upper_z  = lane_res[2].upper;
    assign lane_word.weight_z = lane_res[2].weight;

    assign en        = !skid_full_reg;
    assign pos_ready = en && !busy;
    assign accept    = pos_valid && pos_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vld_next       = vld_reg;
        skid_full_next = skid_full_reg;
        if (en)
        begin
            vld_next = {vld_reg[DEPTH-2:0], accept};
            // output word not taken while the lanes move on: park it
            if (vld_reg[DEPTH-1] && !res_ready)
            begin
                skid_full_next = 1'b1;
            end
        end
        else if (res_ready)
        begin
            skid_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skid_reg <= lane_word;
        end
    end

    assign res_valid = skid_full_reg || vld_reg[DEPTH-1];
    assign res_word  = skid_full_reg ? skid_reg : lane_word;

endmodule

// ===== tb/gnwl_checker.sv =====
// ----------------------------------------------------------------------------
// gnwl_checker
// Watches the position, result and configuration channels of the grid
// neighbour weight locator, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module gnwl_checker
    import gnwl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pos_valid,
    input  logic                 pos_ready,
    input  in_t                  pos_word,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  out_t                 res_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORIGIN_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   pending
);

    logic [SPACING_W-1:0] spacing_q [NUM_AXES];
    logic [VOLUME_W-1:0]  volume_q [NUM_AXES];
    logic [ORIGIN_W-1:0]  origin_q;
    out_t                 expected_locs [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    function automatic axis_res_t locate_axis(logic [SPACING_W-1:0] sp_r,
                                              logic [VOLUME_W-1:0] vol_r,
                                              logic [FIX_W-1:0] org,
                                              logic [POS_W-1:0] pos);
        longint unsigned sp, vol, len, gs, rem, last, last_len, end_pt;
        longint unsigned p, off, lo, up, left, cell_len, w;
        axis_res_t r;
        sp = (sp_r == 0) ? 1 : sp_r;
        vol = vol_r;
        if (vol < VOLUME_MIN) vol = VOLUME_MIN;
        if (vol > VOLUME_MAX) vol = VOLUME_MAX;
        len = vol - 1;
        gs = (len - 1) / sp + 1;
        rem = len - (gs - 1) * sp;
        end_pt = (((sp * (gs - 1)) << 4) + (rem << 3)) & 'h1FFFF;
        gs = gs & 'hFFF;
        last_len = (rem << 4) & 'h1FFFF;
        last = (gs != 0) ? gs - 1 : 0;
        p = longint'(pos) << 4;
        if (p <= org)
        begin
            r = '0;
            return r;
        end
        if (p >= end_pt)
        begin
            r.lower = last[IDX_W-1:0];
            r.upper = last[IDX_W-1:0];
            r.weight = '0;
            return r;
        end
        off = p - org;
        lo = (off >> 4) / sp;
        up = lo + 1;
        left = off - ((lo * sp) << 4);
        // the cell ending at the last node spans half of spacing plus remainder
        if (up == last)
            cell_len = (sp << 3) + (last_len >> 1);
        else
            cell_len = sp << 4;
        if (cell_len == 0) cell_len = 1;
        w = (left << FRAC_BITS) / cell_len;
        if (w > WEIGHT_ONE) w = WEIGHT_ONE;
        if (up > last) up = last;
        r.lower = lo[IDX_W-1:0];
        r.upper = up[IDX_W-1:0];
        r.weight = w[WEIGHT_W-1:0];
        return r;
    endfunction

    function automatic out_t locate_word(in_t w);
        axis_res_t ax, ay, az;
        out_t o;
        ax = locate_axis(spacing_q[0], volume_q[0], origin_q[15:0], w.pos_x);
        ay = locate_axis(spacing_q[1], volume_q[1], origin_q[31:16], w.pos_y);
        az = locate_axis(spacing_q[2], volume_q[2], origin_q[47:32], w.pos_z);
        o = {ax.lower, ax.upper, ax.weight, ay.lower, ay.upper, ay.weight,
             az.lower, az.upper, az.weight};
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                spacing_q[a] = SPACING_RST;
                volume_q[a] = VOLUME_RST;
            end
            origin_q = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SPACING_X, REG_SPACING_Y, REG_SPACING_Z:
                        spacing_q[cfg_index - REG_SPACING_X] = cfg_data[SPACING_W-1:0];
                    REG_VOLUME_X, REG_VOLUME_Y, REG_VOLUME_Z:
                        volume_q[cfg_index - REG_VOLUME_X] = cfg_data[VOLUME_W-1:0];
                    REG_ORIGIN:
                        origin_q = cfg_data;
                    default: ;
                endcase
            end
            if (pos_valid && pos_ready)
                expected_locs.push_back(locate_word(pos_word));
            if (res_valid && res_ready)
            begin
                if (expected_locs.size() == 0)
                begin
                    $display("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_locs.pop_front();
                    if (res_word.lower_x !== want.lower_x)
                        report_mismatch("lower_x", res_word.lower_x, want.lower_x);
                    if (res_word.upper_x !== want.upper_x)
                        report_mismatch("upper_x", res_word.upper_x, want.upper_x);
                    if (res_word.weight_x !== want.weight_x)
                        report_mismatch("weight_x", res_word.weight_x, want.weight_x);
                    if (res_word.lower_y !== want.lower_y)
                        report_mismatch("lower_y", res_word.lower_y, want.lower_y);
                    if (res_word.upper_y !== want.upper_y)
                        report_mismatch("upper_y", res_word.upper_y, want.upper_y);
                    if (res_word.weight_y !== want.weight_y)
                        report_mismatch("weight_y", res_word.weight_y, want.weight_y);
                    if (res_word.lower_z !== want.lower_z)
                        report_mismatch("lower_z", res_word.lower_z, want.lower_z);
                    if (res_word.upper_z !== want.upper_z)
                        report_mismatch("upper_z", res_word.upper_z, want.upper_z);
                    if (res_word.weight_z !== want.weight_z)
                        report_mismatch("weight_z", res_word.weight_z, want.weight_z);
                end
            end
            pending <= expected_locs.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives positions and register writes into the grid neighbour weight
// locator under random idling and back-pressure; a checker predicts results.
// ----------------------------------------------------------------------------
module testbench;
    import gnwl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_ITEMS    = 120;

    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pos_valid = 1'b0;
    logic                 pos_ready;
    in_t                  pos_word = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    out_t                 res_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ORIGIN_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int sent = 0;
    int stall_cycles = 0;
    bit quiet = 0;
    logic [12:0] vol_now [NUM_AXES];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    grid_neighbour_weight_locator dut (
        .clk(clk), .rst_n(rst_n),
        .pos_valid(pos_valid), .pos_ready(pos_ready), .pos_word(pos_word),
        .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gnwl_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .pos_valid(pos_valid), .pos_ready(pos_ready), .pos_word(pos_word),
        .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // no progress on any channel for too long ends the run
    always @(posedge clk)
    begin
        if ((pos_valid && pos_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold to back up the lanes
    initial
    begin
        bit squeezed;
        squeezed = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!squeezed && sent >= 150)
            begin
                squeezed = 1;
                res_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                res_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_pos(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pos_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pos_valid <= 1'b1;
        pos_word <= '{pos_x: x, pos_y: y, pos_z: z};
        do @(posedge clk); while (!pos_ready);
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ORIGIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic drain_results();
        pos_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // one grid setting: spacing, volume and origin per axis; out-of-range index too
    task automatic load_grid(int mode);
        logic [11:0] sp;
        logic [12:0] vol;
        logic [15:0] org;
        logic [ORIGIN_W-1:0] org_all;
        org_all = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            case (mode)
                0:
                begin
                    sp = 12'd1; vol = 13'd2; org = 16'd0;
                end
                1:
                begin
                    sp = 12'd4095; vol = 13'd4096; org = 16'hFFFF;
                end
                2:
                begin
                    sp = 12'd0; vol = 13'($urandom_range(0, 1)); org = 16'd0;
                end
                3:
                begin
                    sp = 12'd1; vol = 13'h1FFF; org = 16'($urandom_range(0, 64));
                end
                4:
                begin
                    sp = 12'($urandom_range(2, 40)); vol = 13'($urandom_range(2, 400));
                    org = 16'($urandom_range(0, 800));
                end
                default:
                begin
                    sp = 12'($urandom_range(1, 4095));
                    vol = 13'($urandom_range(0, 8191)); org = 16'($urandom);
                end
            endcase
            vol_now[a] = vol;
            write_reg(CFG_IDX_W'(REG_SPACING_X + a),
                      48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000 | 48'(sp));
            write_reg(CFG_IDX_W'(REG_VOLUME_X + a),
                      48'({$urandom, $urandom}) & 48'hFFFF_FFFF_E000 | 48'(vol));
            org_all[16*a +: 16] = org;
        end
        write_reg(REG_ORIGIN, org_all);
        write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos(logic [12:0] vol);
        int top;
        top = (vol > 13'd4095 || vol == 0) ? 4095 : int'(vol) + int'(vol) / 8 + 2;
        if (top > 4095) top = 4095;
        if ($urandom_range(0, 7) == 0)
            return POS_W'($urandom);
        return POS_W'($urandom_range(0, top));
    endfunction

    initial
    begin
        int mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset grid: origin, cell borders, grid end, extremes
        send_pos(12'd0, 12'd1, 12'd4095);
        send_pos(12'd63, 12'd64, 12'd65);
        send_pos(12'd127, 12'd128, 12'd191);
        send_pos(12'd192, 12'd200, 12'd222);
        send_pos(12'd223, 12'd224, 12'd255);
        send_pos(12'hAAA, 12'h555, 12'd160);
        for (int i = 0; i < 10; i++)
            send_pos(pick_pos(13'd256), pick_pos(13'd256), pick_pos(13'd256));

        for (int ph = 0; ph < 7; ph++)
        begin
            drain_results();
            mode = (ph < 5) ? ph : 4 + ph % 2;
            if (ph == 6)
                quiet = 1;
            load_grid(mode);
            if (mode == 1)
            begin
                send_pos(12'd4095, 12'd4095, 12'd4095);
                send_pos(12'd0, 12'd2048, 12'd4094);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pos(pick_pos(vol_now[0]), pick_pos(vol_now[1]), pick_pos(vol_now[2]));
        end
        drain_results();

        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
